// ===== design/bcs_pkg.sv =====
// Shared types and constants for the brew cycle sequencer.
`timescale 1ns / 1ps

package bcs_pkg;

   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int SECS_W      = 10;

   localparam logic [SECS_W-1:0] SECS_MAX = '1;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_INFUSE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFUSE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRACT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINISHED   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BREW_TEMP  = 3'd4;

   // register reset values
   localparam logic [7:0]        PRE_INFUSE_RST = 8'd3;
   localparam logic [7:0]        INFUSE_RST     = 8'd3;
   localparam logic [7:0]        EXTRACT_RST    = 8'd25;
   localparam logic [SECS_W-1:0] FINISHED_RST   = 10'd300;
   localparam logic [7:0]        BREW_TEMP_RST  = 8'd98;

   typedef enum logic [2:0] {
      ST_EMPTY    = 3'd0,
      ST_IDLE     = 3'd1,
      ST_WARN     = 3'd2,
      ST_PRE      = 3'd3,
      ST_INFUSE   = 3'd4,
      ST_EXTRACT  = 3'd5,
      ST_FINISHED = 3'd6,
      ST_ERROR    = 3'd7
   } state_type;

   typedef enum logic [2:0] {
      LED_CYAN   = 3'd0,
      LED_GREEN  = 3'd1,
      LED_RED    = 3'd2,
      LED_BLUE   = 3'd3,
      LED_YELLOW = 3'd4,
      LED_PURPLE = 3'd5
   } led_type;

   typedef struct packed {
      logic [7:0]        pre_infuse_seconds;
      logic [7:0]        infuse_seconds;
      logic [7:0]        extract_seconds;
      logic [SECS_W-1:0] finished_seconds;
      logic [7:0]        brew_temperature;
   } cfg_type;

   typedef struct packed {
      logic switch_down;
      logic tank_empty;
      logic tank_low;
      logic button_event;
      logic reset_event;
      logic second_tick;
   } req_type;

   typedef struct packed {
      logic [2:0] current_state;
      logic [2:0] led_color;
      logic       pump_on;
      logic       boiler_on;
      logic       boiler_brewing;
      logic [7:0] boiler_setpoint;
      logic       brew_timer_running;
      logic       shot_pulse;
      logic       error_code;
   } rsp_type;

   typedef struct packed {
      led_type    led;
      logic       pump;
      logic       boiler;
      logic       brewing;
      logic [7:0] setpoint;
      logic       timer;
   } drive_type;

endpackage

// ===== design/bcs_core.sv =====
// Brew state machine: state, second counter, error flag and drive registers.
`timescale 1ns / 1ps

module bcs_core import bcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   state_type         state_ff, state_in;
   logic              entry_ff, entry_in;
   logic [SECS_W-1:0] secs_ff, secs_in;
   logic              err_ff, err_in;
   drive_type         drv_ff, drv_in;

   state_type target;
   logic      target_set;
   logic      shot;

   always_comb begin
      drv_in     = drv_ff;
      err_in     = err_ff;
      target     = state_ff;
      target_set = 1'b0;
      shot       = 1'b0;

      if (entry_ff) begin
         secs_in = '0;
      end else if (req.second_tick && secs_ff != SECS_MAX) begin
         secs_in = secs_ff + 1'b1;
      end else begin
         secs_in = secs_ff;
      end

      case (state_ff)
         ST_EMPTY: begin
            drv_in.led = LED_CYAN;
            if (entry_ff) begin
               drv_in.boiler = 1'b0;
               drv_in.pump   = 1'b0;
            end
            if (!req.tank_empty && req.switch_down) begin
               target = ST_IDLE; target_set = 1'b1;
            end
         end
         ST_IDLE: begin
            if (entry_ff) begin
               drv_in.timer    = 1'b0;
               drv_in.led      = LED_GREEN;
               drv_in.pump     = 1'b0;
               drv_in.brewing  = 1'b0;
               drv_in.boiler   = 1'b1;
               drv_in.setpoint = cfg.brew_temperature;
            end
            if (!req.switch_down) begin
               target = req.tank_low ? ST_WARN : ST_PRE; target_set = 1'b1;
            end
         end
         ST_WARN: begin
            if (entry_ff) begin
               drv_in.led = LED_RED;
            end
            if (req.button_event) begin
               target = ST_PRE; target_set = 1'b1;
            end
         end
         ST_PRE: begin
            if (entry_ff) begin
               drv_in.timer   = 1'b1;
               drv_in.led     = LED_BLUE;
               drv_in.pump    = 1'b1;
               drv_in.brewing = 1'b1;
            end
            if (secs_in >= {2'b00, cfg.pre_infuse_seconds}) begin
               target = ST_INFUSE; target_set = 1'b1;
            end
         end
         ST_INFUSE: begin
            if (entry_ff) begin
               drv_in.brewing = 1'b0;
               drv_in.led     = LED_YELLOW;
               drv_in.pump    = 1'b0;
            end
            if (secs_in >= {2'b00, cfg.infuse_seconds}) begin
               target = ST_EXTRACT; target_set = 1'b1;
            end
         end
         ST_EXTRACT: begin
            if (entry_ff) begin
               drv_in.led     = LED_PURPLE;
               drv_in.pump    = 1'b1;
               drv_in.brewing = 1'b1;
               shot           = 1'b1;
            end
            if (secs_in >= {2'b00, cfg.extract_seconds}) begin
               target = ST_FINISHED; target_set = 1'b1;
            end
         end
         ST_FINISHED: begin
            if (entry_ff) begin
               drv_in.led     = LED_CYAN;
               drv_in.pump    = 1'b0;
               drv_in.brewing = 1'b0;
               drv_in.timer   = 1'b0;
            end
            // timer starts and error latches even if a later move overrides
            if (req.button_event) begin
               drv_in.timer = 1'b1;
               target = ST_EXTRACT; target_set = 1'b1;
            end
            if (secs_in >= cfg.finished_seconds) begin
               err_in = 1'b1;
               target = ST_ERROR; target_set = 1'b1;
            end
         end
         default: begin
            if (entry_ff) begin
               drv_in.led    = LED_RED;
               drv_in.pump   = 1'b0;
               drv_in.timer  = 1'b0;
               drv_in.boiler = 1'b0;
            end
         end
      endcase

      // switch and tank moves shared by every state except empty
      if (state_ff != ST_EMPTY) begin
         if (req.switch_down) begin
            target = ST_IDLE; target_set = 1'b1;
         end
         if (req.tank_empty) begin
            target = ST_EMPTY; target_set = 1'b1;
         end
      end

      if (state_ff == ST_ERROR && req.reset_event) begin
         err_in = 1'b0;
         target = ST_IDLE; target_set = 1'b1;
      end

      if (target_set && target != state_ff) begin
         state_in = target;
         entry_in = 1'b1;
      end else begin
         state_in = state_ff;
         entry_in = 1'b0;
      end

      rsp.current_state      = state_in;
      rsp.led_color          = drv_in.led;
      rsp.pump_on            = drv_in.pump;
      rsp.boiler_on          = drv_in.boiler;
      rsp.boiler_brewing     = drv_in.brewing;
      rsp.boiler_setpoint    = drv_in.setpoint;
      rsp.brew_timer_running = drv_in.timer;
      rsp.shot_pulse         = shot;
      rsp.error_code         = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_ff <= 1'b1;
         secs_ff  <= '0;
         err_ff   <= 1'b0;
         drv_ff   <= '{led: LED_CYAN, pump: 1'b0, boiler: 1'b0, brewing: 1'b0,
                       setpoint: 8'd0, timer: 1'b0};
      end else if (step) begin
         state_ff <= state_in;
         entry_ff <= entry_in;
         secs_ff  <= secs_in;
         err_ff   <= err_in;
         drv_ff   <= drv_in;
      end
   end

   // a shot is counted only on the entry poll of extract
   a_shot_on_entry: assert property (@(posedge clock) disable iff (reset)
      step && shot |-> state_ff == ST_EXTRACT && entry_ff)
      else $error("shot pulse outside extract entry");

   // state holds between polls
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff) && $stable(entry_ff))
      else $error("state moved without a poll");

   // a change of state always arms the entry actions
   a_entry_armed: assert property (@(posedge clock) disable iff (reset)
      step && state_in != state_ff |=> entry_ff)
      else $error("state changed without entry pending");

   // the counter restarts on every entry poll
   a_secs_cleared: assert property (@(posedge clock) disable iff (reset)
      step && entry_ff |=> secs_ff == '0)
      else $error("second counter not cleared on entry");

endmodule

// ===== design/brew_cycle_sequencer_unit.sv =====
// Top level of the brew cycle sequencer: channels, csr registers, item stages.
//
// Usage:
//   Each req_ item is one poll of the brew controller (switch, tank flags,
//   button, reset message, one-second tick). Each poll yields exactly one
//   rsp_ item: the state after the poll, LED, pump and boiler drive, the
//   setpoint, the brew timer flag, a shot pulse and the error code.
//   Both channels use valid/ready; an item moves when both are high.
//   An accepted req_ item sits in the input register until the result
//   register is free or being taken; the state machine logic then loads it.
//   Throughput is one poll per cycle while rsp_ready is high; the state
//   machine advances once per item as it moves from the input register
//   into the result register.
//   When the receiver stalls, the result register holds, the input register
//   fills, and req_ready drops until the result is taken.
//   The csr_ port writes the five timing/setpoint registers by index with
//   no wait; writes to indexes past the last register are dropped. Write
//   only while no item is in flight.
//   Reset (synchronous) empties both stages, loads register defaults and
//   puts the machine in idle with its entry actions pending.
`timescale 1ns / 1ps

module brew_cycle_sequencer_unit import bcs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    in_vld_ff;
   req_type in_ff;
   logic    out_vld_ff;
   rsp_type out_ff;
   cfg_type cfg_ff;
   rsp_type rsp_next;
   logic    advance;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pre_infuse_seconds: PRE_INFUSE_RST, infuse_seconds: INFUSE_RST,
                     extract_seconds: EXTRACT_RST, finished_seconds: FINISHED_RST,
                     brew_temperature: BREW_TEMP_RST};
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRE_INFUSE: cfg_ff.pre_infuse_seconds <= csr_wdata[7:0];
            CSR_INFUSE:     cfg_ff.infuse_seconds     <= csr_wdata[7:0];
            CSR_EXTRACT:    cfg_ff.extract_seconds    <= csr_wdata[7:0];
            CSR_FINISHED:   cfg_ff.finished_seconds   <= csr_wdata[SECS_W-1:0];
            CSR_BREW_TEMP:  cfg_ff.brew_temperature   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   bcs_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

endmodule
